### hdl/r2a_pkg.sv
// shared constants, types and helper functions of the radix to ascii formatter
package r2a_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned MAX_LEN     = 40;
  localparam int unsigned STEP_BITS   = 8;
  localparam int unsigned DIV_STEPS   = VALUE_WIDTH / STEP_BITS;
  localparam int unsigned STEP_W      = $clog2(DIV_STEPS);
  localparam int unsigned IDX_W       = $clog2(VALUE_WIDTH);
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH + 1);

  localparam int unsigned RADIX_W     = 8;
  localparam int unsigned BASE_W      = 5;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned IN_DATA_W   = 48;
  localparam int unsigned OUT_DATA_W  = 16;

  localparam logic [BASE_W-1:0]  BASE_MIN     = 5'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX     = 5'd16;
  localparam logic [LEN_W-1:0]   LEN_MIN      = 6'd1;
  localparam logic [LEN_W-1:0]   LEN_MAX      = LEN_W'(MAX_LEN);
  localparam logic [CHAR_W-1:0]  CH_OVERFLOW  = 8'h3F;
  localparam logic [CHAR_W-1:0]  CH_PAD       = 8'h00;
  localparam logic [CHAR_W-1:0]  ASCII_DIGIT  = 8'h30;
  localparam logic [CHAR_W-1:0]  ASCII_LETTER = 8'h37;
  localparam logic [DIGIT_W-1:0] TEN          = 4'hA;

  typedef struct packed {
    logic load;
    logic div;
    logic rd;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic div_finish;
    logic emit_last;
  } status_t;

  function automatic logic [BASE_W-1:0] clamp_radix(input logic [RADIX_W-1:0] radix);
    logic [BASE_W-1:0] base;
    if (radix < RADIX_W'(BASE_MIN)) begin
      base = BASE_MIN;
    end else if (radix > RADIX_W'(BASE_MAX)) begin
      base = BASE_MAX;
    end else begin
      base = radix[BASE_W-1:0];
    end
    return base;
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    if (len < LEN_MIN) begin
      res = LEN_MIN;
    end else if (len > LEN_MAX) begin
      res = LEN_MAX;
    end else begin
      res = len;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < TEN) begin
      ch = CHAR_W'(d) + ASCII_DIGIT;
    end else begin
      ch = CHAR_W'(d) + ASCII_LETTER;
    end
    return ch;
  endfunction

endpackage

### hdl/radix_to_ascii_formatter.sv
// top level of the radix to ascii formatter
// Takes one unsigned 32-bit value with a radix (clamped to 2..16) and a buffer
// length (clamped to 1..40) and returns exactly buffer-length characters, most
// significant digit first in upper-case ascii, then zero bytes; when the digit
// count reaches the length the run is '?' characters closed by one zero byte.
// One item is worked on at a time. Digits come from a shared divider that
// resolves 8 quotient bits per cycle, and each character then takes a digit
// memory read, then an output transfer once the sink is ready; input is not
// accepted again until the last character has been transferred.
module radix_to_ascii_formatter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  // value [31:0], radix [39:32], buffer_length [45:40], zero fill
  input  logic [r2a_pkg::IN_DATA_W-1:0]      s_tdata_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  // character [7:0], position [13:8], zero fill
  output logic [r2a_pkg::OUT_DATA_W-1:0]     m_tdata_o,
  output logic                               m_tlast_o
);

  r2a_pkg::cmd_t                  cmd;
  r2a_pkg::status_t               status;
  logic [r2a_pkg::CHAR_W-1:0]     character;
  logic [r2a_pkg::LEN_W-1:0]      position;

  r2a_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  r2a_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .value_i         (s_tdata_i[r2a_pkg::VALUE_WIDTH-1:0]),
    .radix_i         (s_tdata_i[39:32]),
    .buffer_length_i (s_tdata_i[45:40]),
    .character_o     (character),
    .position_o      (position),
    .last_o          (m_tlast_o)
  );

  assign m_tdata_o = {2'b00, position, character};

endmodule

### hdl/r2a_ctrl.sv
// controller state machine sequencing division and character transfers
module r2a_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  input  r2a_pkg::status_t  status_i,
  output r2a_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    s_tready_o  = 1'b0;
    m_tvalid_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (status_i.div_finish) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        m_tvalid_o = 1'b1;
        if (m_tready_i) begin
          if (status_i.emit_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/r2a_dp.sv
// datapath: digit divider, digit memory, emit counter and character forming
module r2a_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  r2a_pkg::cmd_t                        cmd_i,
  output r2a_pkg::status_t                     status_o,
  input  logic [r2a_pkg::VALUE_WIDTH-1:0]      value_i,
  input  logic [r2a_pkg::RADIX_W-1:0]          radix_i,
  input  logic [r2a_pkg::LEN_W-1:0]            buffer_length_i,
  output logic [r2a_pkg::CHAR_W-1:0]           character_o,
  output logic [r2a_pkg::LEN_W-1:0]            position_o,
  output logic                                 last_o
);

  logic [r2a_pkg::VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [r2a_pkg::DIGIT_W-1:0]     rem_q, rem_d;
  logic [r2a_pkg::BASE_W-1:0]      base_q;
  logic [r2a_pkg::LEN_W-1:0]       len_q;
  logic [r2a_pkg::STEP_W-1:0]      step_q;
  logic [r2a_pkg::CNT_W-1:0]       cnt_q;
  logic [r2a_pkg::LEN_W-1:0]       idx_q;
  logic [r2a_pkg::DIGIT_W-1:0]     rd_q;
  logic                            in_digits_q;
  logic [r2a_pkg::DIGIT_W-1:0]     mem_q [r2a_pkg::VALUE_WIDTH];

  logic                            step_last;
  logic                            ovf;
  logic [r2a_pkg::CNT_W-1:0]       addr_diff;
  logic [r2a_pkg::IDX_W-1:0]       raddr;

  // restoring division, several quotient bits per cycle
  always_comb begin
    logic [r2a_pkg::BASE_W-1:0] trial;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < r2a_pkg::STEP_BITS; k++) begin
      trial = {rem_d, quo_d[r2a_pkg::VALUE_WIDTH-1]};
      quo_d = {quo_d[r2a_pkg::VALUE_WIDTH-2:0], 1'b0};
      if (trial >= base_q) begin
        trial    = trial - base_q;
        quo_d[0] = 1'b1;
      end
      rem_d = trial[r2a_pkg::DIGIT_W-1:0];
    end
  end

  assign step_last = (step_q == r2a_pkg::STEP_W'(r2a_pkg::DIV_STEPS - 1));
  assign status_o.div_finish = step_last &&
      ((quo_d == '0) || (cnt_q == r2a_pkg::CNT_W'(r2a_pkg::VALUE_WIDTH - 1)));
  assign status_o.emit_last = (idx_q == len_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      step_q <= '0;
      cnt_q  <= '0;
      idx_q  <= '0;
    end else if (cmd_i.load) begin
      quo_q  <= value_i;
      rem_q  <= '0;
      step_q <= '0;
      cnt_q  <= '0;
      idx_q  <= '0;
    end else if (cmd_i.div) begin
      quo_q  <= quo_d;
      step_q <= step_q + 1'b1;
      if (step_last) begin
        rem_q <= '0;
        cnt_q <= cnt_q + 1'b1;
      end else begin
        rem_q <= rem_d;
      end
    end else if (cmd_i.advance) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= r2a_pkg::clamp_radix(radix_i);
      len_q  <= r2a_pkg::clamp_len(buffer_length_i);
    end
  end

  // digit memory, least significant digit first
  assign addr_diff = cnt_q - r2a_pkg::CNT_W'(idx_q) - r2a_pkg::CNT_W'(1);
  assign raddr     = addr_diff[r2a_pkg::IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div && step_last) begin
      mem_q[cnt_q[r2a_pkg::IDX_W-1:0]] <= rem_d;
    end
    if (cmd_i.rd) begin
      rd_q        <= mem_q[raddr];
      in_digits_q <= (r2a_pkg::CNT_W'(idx_q) < cnt_q);
    end
  end

  assign ovf = (r2a_pkg::LEN_W'(cnt_q) >= len_q);

  always_comb begin
    if (ovf) begin
      character_o = status_o.emit_last ? r2a_pkg::CH_PAD : r2a_pkg::CH_OVERFLOW;
    end else if (in_digits_q) begin
      character_o = r2a_pkg::digit_char(rd_q);
    end else begin
      character_o = r2a_pkg::CH_PAD;
    end
  end

  assign position_o = idx_q;
  assign last_o     = status_o.emit_last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q <= r2a_pkg::CNT_W'(r2a_pkg::VALUE_WIDTH))
    else $error("digit count beyond value width");

  a_rem_below_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_i.div |=> (rem_q < base_q))
    else $error("partial remainder not below base");

  a_idx_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_i.rd |-> (idx_q < len_q))
    else $error("emit index beyond buffer length");

  a_finish_resets_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cmd_i.div && status_o.div_finish) |=> (step_q == '0) && (rem_q == '0))
    else $error("divider not cleared after last digit");
`endif

endmodule

### test/radix_to_ascii_formatter_tb.sv
// self-checking testbench of the radix to ascii formatter: directed table, then random items
module radix_to_ascii_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import r2a_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  pos;
    logic              last;
  } char_xfer_t;

  typedef struct {
    logic [31:0]        value;
    logic [RADIX_W-1:0] radix;
    logic [LEN_W-1:0]   len;
    bit                 typed;
    string              text;
  } dir_row_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  s_tvalid_i = 1'b0;
  logic                  s_tready_o;
  logic [IN_DATA_W-1:0]  s_tdata_i  = '0;
  logic                  m_tvalid_o;
  logic                  m_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata_o;
  logic                  m_tlast_o;

  char_xfer_t chars_due[$];
  dir_row_t   dir_rows[$];
  int         mismatches = 0;
  bit         no_idle    = 1'b0;

  radix_to_ascii_formatter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [LEN_W-1:0] run_length(input logic [LEN_W-1:0] req);
    if (req == '0) return LEN_MIN;
    if (req > LEN_MAX) return LEN_MAX;
    return req;
  endfunction

  task automatic queue_formatted(input logic [31:0] value, input logic [RADIX_W-1:0] radix,
                                 input logic [LEN_W-1:0] req_len);
    logic [31:0]        q;
    logic [BASE_W-1:0]  base;
    logic [LEN_W-1:0]   len;
    logic [DIGIT_W-1:0] digits [VALUE_WIDTH];
    logic [DIGIT_W-1:0] d;
    int                 n;
    char_xfer_t         x;
    q = value;
    if (radix < RADIX_W'(BASE_MIN)) base = BASE_MIN;
    else if (radix > RADIX_W'(BASE_MAX)) base = BASE_MAX;
    else base = radix[BASE_W-1:0];
    len = run_length(req_len);
    n = 0;
    do begin
      digits[n] = DIGIT_W'(q % 32'(base));
      q = q / 32'(base);
      n++;
    end while (q != 0 && n < VALUE_WIDTH);
    for (int i = 0; i < len; i++) begin
      if (n >= len) begin
        x.ch = (i == len - 1) ? CH_PAD : CH_OVERFLOW;
      end else if (i >= n) begin
        x.ch = CH_PAD;
      end else begin
        d = digits[n - 1 - i];
        x.ch = (d < TEN) ? CHAR_W'(d) + ASCII_DIGIT : CHAR_W'(d) + ASCII_LETTER;
      end
      x.pos  = LEN_W'(i);
      x.last = (i == len - 1);
      chars_due.push_back(x);
    end
  endtask

  // typed row: the given characters, then zero bytes up to the run length
  task automatic queue_text(input string text, input logic [LEN_W-1:0] req_len);
    logic [LEN_W-1:0] len;
    char_xfer_t       x;
    len = run_length(req_len);
    for (int i = 0; i < len; i++) begin
      x.ch   = (i < text.len()) ? CHAR_W'(text[i]) : CH_PAD;
      x.pos  = LEN_W'(i);
      x.last = (i == len - 1);
      chars_due.push_back(x);
    end
  endtask

  task automatic send_item(input logic [31:0] value, input logic [RADIX_W-1:0] radix,
                           input logic [LEN_W-1:0] len, input bit typed, input string text);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tdata_i  <= {2'b00, len, radix, value};
    s_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_tready_o);
    if (typed) queue_text(text, len);
    else queue_formatted(value, radix, len);
  endtask

  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    char_xfer_t x;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (chars_due.size() == 0) begin
        $display("%0t: unexpected transfer, char %02h pos %0d last %0b", $time,
                 m_tdata_o[7:0], m_tdata_o[13:8], m_tlast_o);
        mismatches++;
      end else begin
        x = chars_due.pop_front();
        if (m_tdata_o[7:0] !== x.ch) begin
          $display("%0t: char expected %02h actual %02h", $time, x.ch, m_tdata_o[7:0]);
          mismatches++;
        end
        if (m_tdata_o[13:8] !== x.pos) begin
          $display("%0t: position expected %0d actual %0d", $time, x.pos, m_tdata_o[13:8]);
          mismatches++;
        end
        if (m_tlast_o !== x.last) begin
          $display("%0t: last expected %0b actual %0b", $time, x.last, m_tlast_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int g;
    @(posedge clk_i);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        m_tready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    #50_000_000;
    $display("radix_to_ascii_formatter test failed");
    $finish;
  end

  initial begin
    logic [31:0]        v;
    logic [RADIX_W-1:0] r;
    logic [LEN_W-1:0]   l;
    int                 pick;

    // value, radix, length, typed, characters before the zero padding
    dir_rows.push_back('{32'd0,        8'd10,  6'd1,  1'b1, ""});
    dir_rows.push_back('{32'd0,        8'd10,  6'd2,  1'b1, "0"});
    dir_rows.push_back('{32'd0,        8'd0,   6'd2,  1'b1, "0"});
    dir_rows.push_back('{32'd5,        8'd10,  6'd0,  1'b1, ""});
    dir_rows.push_back('{32'hFFFFFFFF, 8'd16,  6'd9,  1'b1, "FFFFFFFF"});
    dir_rows.push_back('{32'hFFFFFFFF, 8'd255, 6'd9,  1'b1, "FFFFFFFF"});
    dir_rows.push_back('{32'hFFFFFFFF, 8'd10,  6'd11, 1'b1, "4294967295"});
    dir_rows.push_back('{32'hFFFFFFFF, 8'd10,  6'd10, 1'b1, "?????????"});
    dir_rows.push_back('{32'd12345,    8'd10,  6'd6,  1'b1, "12345"});
    dir_rows.push_back('{32'd12345,    8'd10,  6'd5,  1'b1, "????"});
    dir_rows.push_back('{32'd255,      8'd16,  6'd3,  1'b1, "FF"});
    dir_rows.push_back('{32'hABCDEF,   8'd16,  6'd7,  1'b1, "ABCDEF"});
    dir_rows.push_back('{32'd1000,     8'd36,  6'd4,  1'b1, "3E8"});
    dir_rows.push_back('{32'd9,        8'd17,  6'd2,  1'b1, "9"});
    dir_rows.push_back('{32'd1,        8'd2,   6'd2,  1'b1, "1"});
    dir_rows.push_back('{32'hFFFFFFFF, 8'd2,   6'd33, 1'b0, ""});
    dir_rows.push_back('{32'hFFFFFFFF, 8'd1,   6'd40, 1'b0, ""});
    dir_rows.push_back('{32'hFFFFFFFF, 8'd2,   6'd32, 1'b0, ""});
    dir_rows.push_back('{32'd7,        8'd8,   6'd63, 1'b0, ""});
    dir_rows.push_back('{32'd7,        8'd8,   6'd41, 1'b0, ""});
    dir_rows.push_back('{32'h80000000, 8'd2,   6'd40, 1'b0, ""});
    dir_rows.push_back('{32'h12345678, 8'd3,   6'd30, 1'b0, ""});
    dir_rows.push_back('{32'hDEADBEEF, 8'd7,   6'd20, 1'b0, ""});
    dir_rows.push_back('{32'h55555555, 8'd4,   6'd17, 1'b0, ""});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].value, dir_rows[i].radix, dir_rows[i].len,
                dir_rows[i].typed, dir_rows[i].text);
    wait_drained();

    for (int k = 0; k < 470; k++) begin
      no_idle = (k >= 150 && k < 210);
      pick = $urandom_range(99);
      if (pick < 35) v = $urandom();
      else if (pick < 60) v = $urandom_range(0, 255);
      else if (pick < 75) v = 32'd1 << $urandom_range(0, 31);
      else if (pick < 90) v = (32'd1 << $urandom_range(0, 31)) - 32'd1;
      else if (pick < 95) v = 32'hFFFFFFFF;
      else v = 32'd0;
      r = ($urandom_range(99) < 80) ? RADIX_W'($urandom_range(2, 16))
                                    : RADIX_W'($urandom_range(0, 255));
      pick = $urandom_range(99);
      if (pick < 60) l = LEN_W'($urandom_range(1, 12));
      else if (pick < 90) l = LEN_W'($urandom_range(13, 40));
      else if (pick < 93) l = '0;
      else l = LEN_W'($urandom_range(41, 63));
      send_item(v, r, l, 1'b0, "");
      if (k % 60 == 59) wait_drained();
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("radix_to_ascii_formatter test passed");
    end else begin
      $display("radix_to_ascii_formatter test failed");
    end
    $finish;
  end

endmodule
